FILE: rtl/spr_pkg.sv
package spr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_ITER  = 64;
	localparam int MAX_DEGREE = 4;
	localparam int NUM_COEF  = 5;
	localparam int CNT_W     = 7;
	localparam int DIV_W     = 64;
	localparam int DIV_CNT_W = 7;

	localparam logic [2:0] REG_DEGREE = 3'd0;
	localparam logic [2:0] REG_COEF4  = 3'd1;
	localparam logic [2:0] REG_COEF3  = 3'd2;
	localparam logic [2:0] REG_COEF2  = 3'd3;
	localparam logic [2:0] REG_COEF1  = 3'd4;
	localparam logic [2:0] REG_COEF0  = 3'd5;
	localparam logic [2:0] REG_TOL    = 3'd6;

	localparam logic [2:0] ST_CONVERGED  = 3'd0;
	localparam logic [2:0] ST_EXACT_ZERO = 3'd1;
	localparam logic [2:0] ST_INVALID    = 3'd2;
	localparam logic [2:0] ST_FLAT       = 3'd3;
	localparam logic [2:0] ST_ITER_LIMIT = 3'd4;

	localparam logic [33:0] STEP_CLAMP = 34'h2_0000_0000;

	typedef struct packed {
		logic load;        // take guesses: a<-guess_a, b<-guess_b, x<-guess_a
		logic eval_start;  // start horner on x
		logic save_fa;     // f result -> fa, then x<-b
		logic save_fb;     // f result -> fb
		logic div_start;   // form product, start divider
		logic step;        // form c from quotient, x<-c
		logic save_fc;     // f result -> fc
		logic advance;     // a<-b, fa<-fb, b<-c, fb<-fc, x stays
	} spr_cmd_t;

	typedef struct packed {
		logic eval_done;
		logic div_done;
		logic sign_ok;
		logic den_zero;
		logic fc_zero;
		logic conv;
	} spr_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

endpackage

FILE: rtl/secant_polynomial_root_finder_top.sv
// Secant root finder for a polynomial of degree one to four in signed Q16.16.
// Each request carries two guesses and yields one result: root estimate,
// status (0 converged, 1 exact zero, 2 invalid guesses, 3 flat secant,
// 4 iteration limit) and the number of secant steps. One request is worked
// at a time. Each secant step runs a bit-serial divider plus one polynomial
// evaluation, and a request ends with a result at the latest at the 64-step
// limit. Write configuration only while idle.
module secant_polynomial_root_finder_top import spr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic        [2:0]  cfg_index,
	input  logic        [31:0] cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] guess_a,
	input  logic signed [31:0] guess_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] root_estimate,
	output logic        [2:0]  status,
	output logic        [6:0]  iteration_count
);
	logic        [2:0]  degree_q;
	logic signed [31:0] c4_q, c3_q, c2_q, c1_q, c0_q;
	logic        [30:0] tol_q;
	spr_cmd_t           cmd;
	spr_stat_t          stat;
	logic               sel_c;
	logic signed [31:0] b_val, c_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= 3'd1;
			c4_q     <= '0;
			c3_q     <= '0;
			c2_q     <= '0;
			c1_q     <= 32'sd65536;
			c0_q     <= '0;
			tol_q    <= 31'd66;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEGREE: degree_q <= cfg_data[2:0];
				REG_COEF4:  c4_q     <= cfg_data;
				REG_COEF3:  c3_q     <= cfg_data;
				REG_COEF2:  c2_q     <= cfg_data;
				REG_COEF1:  c1_q     <= cfg_data;
				REG_COEF0:  c0_q     <= cfg_data;
				REG_TOL:    tol_q    <= cfg_data[30:0];
				default:    ;
			endcase
		end
	end

	spr_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cmd             (cmd),
		.stat            (stat),
		.sel_c           (sel_c),
		.status          (status),
		.iteration_count (iteration_count)
	);

	spr_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.poly_degree (degree_q),
		.coef_x4     (c4_q),
		.coef_x3     (c3_q),
		.coef_x2     (c2_q),
		.coef_x1     (c1_q),
		.coef_x0     (c0_q),
		.tolerance   (tol_q),
		.guess_a     (guess_a),
		.guess_b     (guess_b),
		.b_val       (b_val),
		.c_val       (c_val)
	);

	assign root_estimate = sel_c ? c_val : b_val;
endmodule

FILE: rtl/spr_divider.sv
module spr_divider import spr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  dividend,
	input  logic [32:0]       divisor,
	output logic              done,
	output logic [DIV_W-1:0]  quotient
);
	logic [DIV_W-1:0]     quo_q;
	logic [33:0]          rem_q;
	logic [32:0]          dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [34:0]          trial;
	logic [33:0]          shifted;

	assign shifted = {rem_q[32:0], quo_q[DIV_W-1]};
	assign trial   = {1'b0, shifted} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

FILE: rtl/spr_datapath.sv
module spr_datapath import spr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  spr_cmd_t           cmd,
	output spr_stat_t          stat,
	input  logic        [2:0]  poly_degree,
	input  logic signed [31:0] coef_x4,
	input  logic signed [31:0] coef_x3,
	input  logic signed [31:0] coef_x2,
	input  logic signed [31:0] coef_x1,
	input  logic signed [31:0] coef_x0,
	input  logic        [30:0] tolerance,
	input  logic signed [31:0] guess_a,
	input  logic signed [31:0] guess_b,
	output logic signed [31:0] b_val,
	output logic signed [31:0] c_val
);
	logic signed [31:0] a_q, b_q, c_q, x_q, fa_q, fb_q, fc_q, acc_q;
	logic signed [63:0] prod_q;
	logic        [2:0]  k_q;
	logic        [1:0]  ph_q;   // 0 idle, 1 multiply, 2 add
	logic               eval_done_q;
	logic        [2:0]  deg;
	logic signed [31:0] coef_sel;
	logic signed [31:0] top_coef;
	logic signed [32:0] den;
	logic signed [32:0] diff;
	logic        [32:0] den_mag, diff_mag, fb_mag;
	logic               neg_q;
	logic        [63:0] mprod_q;
	logic               div_start_q;
	logic               div_done;
	logic        [63:0] quo;
	logic        [33:0] qm;
	logic signed [34:0] step_v;
	logic signed [33:0] cmb_diff;
	logic        [33:0] cb_mag;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;

	always_comb begin
		if (poly_degree == 3'd0)
			deg = 3'd1;
		else if (poly_degree > 3'(MAX_DEGREE))
			deg = 3'(MAX_DEGREE);
		else
			deg = poly_degree;
	end

	function automatic logic signed [31:0] coef_of(input logic [2:0] k,
		input logic signed [31:0] c4, input logic signed [31:0] c3,
		input logic signed [31:0] c2, input logic signed [31:0] c1,
		input logic signed [31:0] c0);
		case (k)
			3'd4: return c4;
			3'd3: return c3;
			3'd2: return c2;
			3'd1: return c1;
			3'd0: return c0;
			default: return '0;
		endcase
	endfunction

	assign top_coef = coef_of(deg, coef_x4, coef_x3, coef_x2, coef_x1, coef_x0);
	assign coef_sel = coef_of(k_q, coef_x4, coef_x3, coef_x2, coef_x1, coef_x0);

	// horner: multiply stage then floor shift, saturate, add
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= 2'd0;
			eval_done_q <= 1'b0;
		end else begin
			eval_done_q <= 1'b0;
			if (cmd.eval_start) begin
				ph_q <= 2'd1;
			end else if (ph_q == 2'd1) begin
				ph_q <= 2'd2;
			end else if (ph_q == 2'd2) begin
				if (k_q == 3'd0) begin
					ph_q        <= 2'd0;
					eval_done_q <= 1'b1;
				end else
					ph_q <= 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval_start) begin
			acc_q <= top_coef;
			k_q   <= deg;
		end else if (ph_q == 2'd1) begin
			prod_q <= acc_q * x_q;
			k_q    <= k_q - 3'd1;
		end else if (ph_q == 2'd2) begin
			acc_q <= sat32(66'(sat32(66'(prod_q >>> FRAC_BITS))) + 66'(coef_sel));
		end
	end

	assign den  = 33'(fb_q) - 33'(fa_q);
	assign diff = 33'(b_q) - 33'(a_q);
	assign den_mag  = den[32]  ? 33'(-den)  : 33'(den);
	assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
	assign fb_mag   = fb_q[31] ? 33'(-33'(fb_q)) : 33'(fb_q);
	assign mul_a = $signed(diff_mag);
	assign mul_b = $signed(fb_mag);
	assign mul_full = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_start_q <= 1'b0;
		else
			div_start_q <= cmd.div_start;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			mprod_q <= mul_full[63:0];
			neg_q   <= (diff[32] ^ fb_q[31] ^ den[32]) && (diff != 0) && (fb_q != 0);
		end
	end

	spr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (mprod_q),
		.divisor  (den_mag),
		.done     (div_done),
		.quotient (quo)
	);

	assign qm = (quo > 64'(STEP_CLAMP)) ? STEP_CLAMP : quo[33:0];
	assign step_v = neg_q ? -35'($signed({1'b0, qm})) : 35'($signed({1'b0, qm}));
	assign cmb_diff = 34'(c_q) - 34'(b_q);
	assign cb_mag = cmb_diff[33] ? 34'(-cmb_diff) : 34'(cmb_diff);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= guess_a;
			b_q <= guess_b;
			x_q <= guess_a;
		end
		if (cmd.save_fa) begin
			fa_q <= acc_q;
			x_q  <= b_q;
		end
		if (cmd.save_fb)
			fb_q <= acc_q;
		if (cmd.step) begin
			c_q <= sat32(66'(b_q) - 66'(step_v));
			x_q <= sat32(66'(b_q) - 66'(step_v));
		end
		if (cmd.save_fc)
			fc_q <= acc_q;
		if (cmd.advance) begin
			a_q  <= b_q;
			fa_q <= fb_q;
			b_q  <= c_q;
			fb_q <= fc_q;
		end
	end

	assign stat.eval_done = eval_done_q;
	assign stat.div_done  = div_done;
	assign stat.sign_ok   = (fa_q[31] != fb_q[31]) && (fa_q != 0) && (fb_q != 0);
	assign stat.den_zero  = (den == 0);
	assign stat.fc_zero   = (fc_q == 0);
	assign stat.conv      = cb_mag < 34'(tolerance);
	assign b_val = b_q;
	assign c_val = c_q;
endmodule

FILE: rtl/spr_ctrl.sv
module spr_ctrl import spr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output spr_cmd_t         cmd,
	input  spr_stat_t        stat,
	output logic             sel_c,
	output logic [2:0]       status,
	output logic [CNT_W-1:0] iteration_count
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVA    = 4'd1;
	localparam logic [3:0] S_EVB0   = 4'd2;
	localparam logic [3:0] S_EVB    = 4'd3;
	localparam logic [3:0] S_CHK    = 4'd4;
	localparam logic [3:0] S_DIVW   = 4'd5;
	localparam logic [3:0] S_STEP   = 4'd6;
	localparam logic [3:0] S_EVC    = 4'd8;
	localparam logic [3:0] S_TEST   = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;
	localparam logic [3:0] S_LOAD   = 4'd11;

	logic [3:0]       state_q;
	logic [CNT_W-1:0] n_q;
	logic [2:0]       status_q;
	logic             sel_c_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_LOAD:  cmd.eval_start = 1'b1;
			S_EVA:   cmd.save_fa = stat.eval_done;
			S_EVB0:  cmd.eval_start = 1'b1;
			S_EVB:   cmd.save_fb = stat.eval_done;
			// the sign change is only required of the initial guesses
			S_CHK:   cmd.div_start = (stat.sign_ok || n_q != '0) && !stat.den_zero;
			S_DIVW:  cmd.step = stat.div_done;
			S_STEP:  cmd.eval_start = 1'b1;
			S_EVC:   cmd.save_fc = stat.eval_done;
			S_TEST:  cmd.advance = !stat.fc_zero && !stat.conv && (n_q < CNT_W'(MAX_ITER));
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			status_q <= ST_INVALID;
			sel_c_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_LOAD;
					n_q     <= '0;
					sel_c_q <= 1'b0;
				end
				S_LOAD: state_q <= S_EVA;
				S_EVA:  if (stat.eval_done) state_q <= S_EVB0;
				S_EVB0: state_q <= S_EVB;
				S_EVB:  if (stat.eval_done) state_q <= S_CHK;
				S_CHK: begin
					if (!stat.sign_ok && n_q == '0) begin
						status_q <= ST_INVALID;
						state_q  <= S_OUT;
					end else if (stat.den_zero) begin
						status_q <= ST_FLAT;
						sel_c_q  <= 1'b0;
						state_q  <= S_OUT;
					end else
						state_q <= S_DIVW;
				end
				S_DIVW: if (stat.div_done) begin
					state_q <= S_STEP;
					n_q     <= n_q + 1'b1;
				end
				S_STEP: state_q <= S_EVC;
				S_EVC:  if (stat.eval_done) state_q <= S_TEST;
				S_TEST: begin
					if (stat.fc_zero) begin
						status_q <= ST_EXACT_ZERO;
						sel_c_q  <= 1'b1;
						state_q  <= S_OUT;
					end else if (stat.conv) begin
						status_q <= ST_CONVERGED;
						sel_c_q  <= 1'b1;
						state_q  <= S_OUT;
					end else if (n_q >= CNT_W'(MAX_ITER)) begin
						status_q <= ST_ITER_LIMIT;
						sel_c_q  <= 1'b1;
						state_q  <= S_OUT;
					end else begin
						sel_c_q <= 1'b0;
						state_q <= S_CHK;
					end
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sel_c           = sel_c_q;
	assign status          = status_q;
	assign iteration_count = n_q;
endmodule
